// ===== rtl/icr_pkg.sv =====
// Package: widths, step state and controller states for the integer cube root block.
package icr_pkg;

    // Radicand width and the number of three-bit digit groups it spans
    localparam int RADICAND_BITS = 31;
    localparam int STEPS         = (RADICAND_BITS + 2) / 3;

    // Width of the root field on the port
    localparam int ROOT_BITS     = 11;

    // Internal widths of the digit-by-digit datapath
    localparam int ROOT_W = STEPS;
    localparam int SQ_W   = 2 * STEPS;
    localparam int PAD_W  = 3 * STEPS;
    localparam int B_W    = 2 * STEPS + 2;
    localparam int REM_W  = (PAD_W > B_W) ? PAD_W : B_W;
    localparam int CNT_W  = $clog2(STEPS + 1);

    // Partial remainder, partial root and its square, carried between steps
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   sq;
    } t_step_state;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== rtl/icr_step.sv =====
// Shared step unit: one bit of the cube root per use, from one three-bit radicand group.
module icr_step (
    input  icr_pkg::t_step_state i_cur,
    input  logic [2:0]           i_bits,
    output icr_pkg::t_step_state o_nxt
);
    import icr_pkg::*;

    logic [ROOT_W-1:0] w_ys;
    logic [SQ_W-1:0]   w_y2s;
    logic [REM_W-1:0]  w_rsh;
    logic [REM_W-1:0]  w_b;
    logic              w_take;

    // Double the root, shift in the next digit group, and try 3y(y+1)+1
    always_comb begin
        w_ys   = i_cur.root << 1;
        w_y2s  = i_cur.sq << 2;
        w_rsh  = REM_W'({i_cur.rem, i_bits});
        w_b    = REM_W'(w_y2s) + (REM_W'(w_y2s) << 1)
               + REM_W'(w_ys) + (REM_W'(w_ys) << 1) + REM_W'(1);
        w_take = (w_rsh >= w_b);

        o_nxt.rem  = w_take ? (w_rsh - w_b) : w_rsh;
        o_nxt.root = w_take ? (w_ys + ROOT_W'(1)) : w_ys;
        o_nxt.sq   = w_take ? (w_y2s + (SQ_W'(w_ys) << 1) + SQ_W'(1)) : w_y2s;
    end

endmodule

// ===== rtl/integer_cube_root.sv =====
// Floor cube root of a 31-bit unsigned radicand, one root bit per three-bit radicand group.
// It runs 11 digit steps, one per cycle, but the last step waits while the output register is full.
// A new radicand is taken only in idle, after the last step: the single shared step unit serves one.
// A finished root waits in the output register while the next radicand is taken.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops o_valid.
module integer_cube_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [icr_pkg::RADICAND_BITS-1:0]   i_radicand,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [icr_pkg::ROOT_BITS-1:0]       o_root
);
    import icr_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PAD_W-1:0]  r_rad, n_rad;
    t_step_state       r_cur, n_cur;
    logic [ROOT_BITS-1:0] r_root, n_root;
    logic              r_out_valid, n_out_valid;

    t_step_state       w_step;
    logic              w_last;
    logic              w_out_free;
    logic              w_accept;
    logic              w_step_en;
    logic              w_finish;

    // Shared digit step unit
    icr_step u_step (
        .i_cur  (r_cur),
        .i_bits (r_rad[PAD_W-1 -: 3]),
        .o_nxt  (w_step)
    );

    assign w_last     = (r_cnt == '0);
    assign w_out_free = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_last && w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        o_ready   = 1'b0;
        w_step_en = 1'b0;
        w_finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_RUN: begin
                w_step_en = !w_last || w_out_free;
                w_finish  = w_last && w_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_valid && o_ready;

    // Load a new radicand, advance one digit, or hold
    always_comb begin
        n_cnt       = r_cnt;
        n_rad       = r_rad;
        n_cur       = r_cur;
        n_root      = r_root;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) n_out_valid = 1'b0;
        if (w_accept) begin
            n_rad = PAD_W'(i_radicand);
            n_cur = '0;
            n_cnt = CNT_W'(STEPS - 1);
        end else if (w_step_en) begin
            n_rad = r_rad << 3;
            n_cur = w_step;
            if (!w_last) n_cnt = r_cnt - CNT_W'(1);
        end
        if (w_finish) begin
            n_root      = ROOT_BITS'(w_step.root);
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_cur  <= n_cur;
        r_root <= n_root;
    end

    assign o_valid = r_out_valid;
    assign o_root  = r_root;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for integer_cube_root: queued radicands, random flow control, checked floor roots.
`timescale 1ns / 1ps

module tb_top;

    import icr_pkg::*;

    localparam logic [RADICAND_BITS-1:0] RADICAND_MAX = {RADICAND_BITS{1'b1}};
    localparam int                       RANDOM_ITEMS = 950;
    localparam int                       SETTLE_CYCLES = 40;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic                     o_ready;
    logic [RADICAND_BITS-1:0] i_radicand = '0;
    logic                     o_valid;
    logic                     i_ready    = 1'b0;
    logic [ROOT_BITS-1:0]     o_root;

    // Radicands waiting to be driven, and roots waiting to come out
    logic [RADICAND_BITS-1:0] radicand_queue [$];
    logic [ROOT_BITS-1:0]     root_queue     [$];
    logic [RADICAND_BITS-1:0] radicand_log   [$];

    int  total_items   = 0;
    int  sent_items    = 0;
    int  checked_roots = 0;
    int  error_count   = 0;
    bit  holding;

    integer_cube_root dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_radicand (i_radicand),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_root     (o_root)
    );

    // Floor cube root, one binary root digit per three radicand bits
    function automatic logic [ROOT_BITS-1:0] cube_root_floor(
        input logic [RADICAND_BITS-1:0] value
    );
        logic [63:0] rest;
        logic [63:0] partial;
        logic [63:0] step_term;
        rest    = 64'(value);
        partial = 64'd0;
        for (int shift = 63; shift >= 0; shift -= 3) begin
            partial   = partial << 1;
            step_term = 64'd3 * partial * (partial + 64'd1) + 64'd1;
            if ((rest >> shift) >= step_term) begin
                rest    = rest - (step_term << shift);
                partial = partial + 64'd1;
            end
        end
        return partial[ROOT_BITS-1:0];
    endfunction

    // Idle percentage per side: sender-heavy, receiver-heavy, then none
    function automatic int idle_percent(input bit receiver_side);
        int phase;
        phase = (total_items == 0) ? 0 : (sent_items * 3) / total_items;
        case (phase)
            0:       return receiver_side ? 84 : 28;
            1:       return receiver_side ? 28 : 84;
            default: return 0;
        endcase
    endfunction

    // Cube of a candidate root, clipped to the radicand range
    function automatic logic [RADICAND_BITS-1:0] near_cube(input int base, input int offset);
        longint cube;
        cube = longint'(base) * base * base + offset;
        if (cube < 0)
            cube = 0;
        if (cube > longint'(RADICAND_MAX))
            cube = longint'(RADICAND_MAX);
        return cube[RADICAND_BITS-1:0];
    endfunction

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Driver: present queued radicands, hold until transfer, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            holding = i_valid;
            if (i_valid && o_ready) begin
                root_queue.push_back(cube_root_floor(i_radicand));
                radicand_log.push_back(i_radicand);
                sent_items++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (radicand_queue.size() > 0 && $urandom_range(0, 99) >= idle_percent(1'b0)) begin
                    i_valid    <= 1'b1;
                    i_radicand <= radicand_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each root transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (root_queue.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected root, expected none, actual %0d", $time, o_root);
                end else begin
                    if (o_root !== root_queue[0]) begin
                        error_count++;
                        $display("%0t: root of %0d, expected %0d, actual %0d",
                                 $time, radicand_log[0], root_queue[0], o_root);
                    end
                    void'(root_queue.pop_front());
                    void'(radicand_log.pop_front());
                    checked_roots++;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= idle_percent(1'b1));
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int base;
        int pick;
        // Directed: zero, range ends, cubes and their neighbors, bit patterns
        radicand_queue.push_back('0);
        radicand_queue.push_back(RADICAND_BITS'(1));
        radicand_queue.push_back(RADICAND_BITS'(7));
        radicand_queue.push_back(RADICAND_BITS'(8));
        radicand_queue.push_back(RADICAND_BITS'(26));
        radicand_queue.push_back(RADICAND_BITS'(27));
        radicand_queue.push_back(RADICAND_BITS'(999));
        radicand_queue.push_back(RADICAND_BITS'(1000));
        radicand_queue.push_back(RADICAND_BITS'(999999));
        radicand_queue.push_back(RADICAND_BITS'(1000000));
        radicand_queue.push_back(RADICAND_BITS'(999999999));
        radicand_queue.push_back(RADICAND_BITS'(1000000000));
        radicand_queue.push_back(near_cube(1289, 0));
        radicand_queue.push_back(near_cube(1290, -1));
        radicand_queue.push_back(near_cube(1290, 0));
        radicand_queue.push_back(near_cube(1290, 1));
        radicand_queue.push_back(RADICAND_MAX);
        radicand_queue.push_back(RADICAND_MAX - 1'b1);
        radicand_queue.push_back(RADICAND_BITS'(1) << (RADICAND_BITS - 1));
        radicand_queue.push_back(RADICAND_BITS'(32'h5555_5555));
        radicand_queue.push_back(RADICAND_BITS'(32'h2AAA_AAAA));
        radicand_queue.push_back(RADICAND_BITS'(32'h7FFF_0000));
        radicand_queue.push_back(RADICAND_BITS'(32'h0000_FFFF));
        // Random: uniform, near perfect cubes, shortened widths, small values
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                radicand_queue.push_back(RADICAND_BITS'($urandom()));
            end else if (pick < 14) begin
                base = $urandom_range(0, 1290);
                radicand_queue.push_back(near_cube(base, $urandom_range(0, 2) - 1));
            end else if (pick < 17) begin
                radicand_queue.push_back(RADICAND_BITS'($urandom()) >> $urandom_range(1, 30));
            end else begin
                radicand_queue.push_back(RADICAND_BITS'($urandom_range(0, 1000)));
            end
        end
        total_items = radicand_queue.size();

        // Hold reset, then release at a clock edge
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all radicands sent and every root back, then let the pipe settle
        while (radicand_queue.size() > 0 || sent_items < total_items || root_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (root_queue.size() > 0) begin
            error_count++;
            $display("%0t: roots still outstanding, expected 0, actual %0d",
                     $time, root_queue.size());
        end

        $display("Ran %0d radicands (zero, range ends, cubes and neighbors, random) and",
                 sent_items);
        $display("checked %0d roots under sender-heavy, receiver-heavy and free-flowing phases.",
                 checked_roots);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
